// ----- hw/rtl/bums_pkg.sv -----
// Shared types and codes for the bottom-up merge sort engine.
// No dependencies; imported by the top level.
package bums_pkg;

	localparam int VALUE_W = 32;

	typedef logic signed [VALUE_W-1:0] value_t;

	// Item kinds carried on the input tuser bit
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	// Result flags, empty in the lowest bit
	typedef struct packed {
		logic overflow;
		logic empty;
	} res_user_t;

	// Sequencer state codes
	localparam int ST_W = 3;
	localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
	localparam logic [ST_W-1:0] ST_PAIR  = 3'd1;
	localparam logic [ST_W-1:0] ST_RD    = 3'd2;
	localparam logic [ST_W-1:0] ST_WR    = 3'd3;
	localparam logic [ST_W-1:0] ST_FETCH = 3'd4;

endpackage

// ----- hw/rtl/bums_ram.sv -----
// Generic synchronous RAM: one write port, two read ports, registered reads.
// Standalone; instanced twice by the sort engine as ping-pong banks.
module bums_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, then register both read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ----- hw/rtl/bottom_up_merge_sort.sv -----
// Bottom-up merge sort engine: load, sort by ping-pong merge passes, fetch.
// Depends on bums_pkg and bums_ram.
//
// Channel  Dir  tdata           tuser                      tlast
// s_axis   in   value[31:0]     op (0 load, 1 fetch)       last of set (load)
// m_axis   out  value_res[31:0] empty_res[0], overflow[1]  last_res
//
// A load writes its value into the current bank as the beat is taken. A fetch
// reads through the registered bank read port, then lands in the output register.
// After the last load the sort runs ceil(log2 n) passes, the run width w doubling
// each pass; each merged element takes a bank read (ST_RD), then a compare and
// write to the other bank (ST_WR); no items are taken during the sort.
// Reset clears counters and flags at once; the banks need no clearing pass.
// A result waiting on m_axis holds off new input beats until it is taken.
module bottom_up_merge_sort
	import bums_pkg::*;
#(
	parameter int MAX_ITEMS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // value[31:0]
	input  logic        s_axis_tuser,   // op
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // value_res[31:0]
	output logic [1:0]  m_axis_tuser,   // empty_res, overflow
	output logic        m_axis_tlast
);

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int AW = $clog2(MAX_ITEMS);
	localparam int SW = CW + 2;

	logic [ST_W-1:0] state_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   rd_idx_q;
	logic            ovf_q;
	logic            sorted_q;
	logic            bank_q;
	logic [SW-1:0]   w_q;
	logic [SW-1:0]   base_q;
	logic [SW-1:0]   l_q;
	logic [SW-1:0]   r_q;
	logic [SW-1:0]   mid_q;
	logic [SW-1:0]   hi_q;
	logic [SW-1:0]   k_q;
	logic            fetch_hit_q;
	logic            fetch_last_q;
	logic            out_valid_q;
	value_t          out_data_q;
	logic            out_last_q;
	res_user_t       out_user_q;

	logic          in_beat;
	logic          load_beat;
	logic          fetch_beat;
	logic [CW-1:0] cnt_base;
	logic          load_fits;
	logic [CW-1:0] cnt_next;
	logic [SW-1:0] n_ext;
	logic [SW-1:0] w2;
	logic [SW-1:0] sum_mid;
	logic [SW-1:0] sum_hi;
	logic [SW-1:0] pair_mid;
	logic [SW-1:0] pair_hi;
	logic [SW-1:0] k_inc;
	logic          take_left;
	logic          fetch_hit;
	value_t        rd_a;
	value_t        rd_b;
	logic [31:0]   rd0_a, rd0_b, rd1_a, rd1_b;
	logic          load_we;
	logic          sort_we;
	logic          we0, we1;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;
	logic [AW-1:0] raddr_a;
	logic [AW-1:0] raddr_b;

	// Input handshake and load bookkeeping
	assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
	assign in_beat    = s_axis_tvalid && s_axis_tready;
	assign load_beat  = in_beat && (s_axis_tuser == OP_LOAD);
	assign fetch_beat = in_beat && (s_axis_tuser == OP_FETCH);
	assign cnt_base   = sorted_q ? '0 : count_q;
	assign load_fits  = cnt_base < CW'(MAX_ITEMS);
	assign cnt_next   = load_fits ? cnt_base + 1'b1 : cnt_base;
	assign fetch_hit  = sorted_q && (rd_idx_q < count_q);

	// Run bounds for the next pair, clipped to the set size
	assign n_ext    = SW'(count_q);
	assign w2       = w_q << 1;
	assign sum_mid  = base_q + w_q;
	assign sum_hi   = base_q + w2;
	assign pair_mid = (sum_mid < n_ext) ? sum_mid : n_ext;
	assign pair_hi  = (sum_hi < n_ext) ? sum_hi : n_ext;
	assign k_inc    = k_q + 1'b1;

	// Source bank heads and stable merge choice
	assign rd_a = value_t'(bank_q ? rd1_a : rd0_a);
	assign rd_b = value_t'(bank_q ? rd1_b : rd0_b);
	assign take_left = (l_q < mid_q) && ((r_q >= hi_q) || (rd_a <= rd_b));

	// Bank port steering: loads fill the current bank, merges write the other
	assign load_we = load_beat && load_fits;
	assign sort_we = (state_q == ST_WR);
	assign we0     = (load_we && !bank_q) || (sort_we && bank_q);
	assign we1     = (load_we && bank_q) || (sort_we && !bank_q);
	assign waddr   = sort_we ? k_q[AW-1:0] : cnt_base[AW-1:0];
	assign wdata   = sort_we ? (take_left ? rd_a : rd_b) : s_axis_tdata;
	assign raddr_a = (state_q == ST_IDLE) ? rd_idx_q[AW-1:0] : l_q[AW-1:0];
	assign raddr_b = r_q[AW-1:0];

	bums_ram #(
		.WIDTH(32),
		.DEPTH(MAX_ITEMS)
	) u_bank0 (
		.clk    (clk),
		.we     (we0),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.rdata_a(rd0_a),
		.raddr_b(raddr_b),
		.rdata_b(rd0_b)
	);

	bums_ram #(
		.WIDTH(32),
		.DEPTH(MAX_ITEMS)
	) u_bank1 (
		.clk    (clk),
		.we     (we1),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.rdata_a(rd1_a),
		.raddr_b(raddr_b),
		.rdata_b(rd1_b)
	);

	// Sequencer: loads, merge passes and fetch lookups
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			rd_idx_q     <= '0;
			ovf_q        <= 1'b0;
			sorted_q     <= 1'b0;
			bank_q       <= 1'b0;
			fetch_hit_q  <= 1'b0;
			fetch_last_q <= 1'b0;
			w_q          <= '0;
			base_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (load_beat) begin
						count_q <= cnt_next;
						if (sorted_q) begin
							ovf_q <= !load_fits;
						end else if (!load_fits) begin
							ovf_q <= 1'b1;
						end
						if (sorted_q || s_axis_tlast) begin
							rd_idx_q <= '0;
						end
						// a set of one value is already in order
						sorted_q <= s_axis_tlast && (cnt_next < CW'(2));
						if (s_axis_tlast && (cnt_next >= CW'(2))) begin
							w_q     <= SW'(1);
							base_q  <= '0;
							state_q <= ST_PAIR;
						end
					end else if (fetch_beat) begin
						fetch_hit_q  <= fetch_hit;
						fetch_last_q <= (rd_idx_q + 1'b1) == count_q;
						if (fetch_hit) begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
						state_q <= ST_FETCH;
					end
				end
				ST_PAIR: begin
					state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					if (k_inc == hi_q) begin
						if (hi_q == n_ext) begin
							bank_q <= !bank_q;
							w_q    <= w2;
							base_q <= '0;
							if (w2 >= n_ext) begin
								sorted_q <= 1'b1;
								rd_idx_q <= '0;
								state_q  <= ST_IDLE;
							end else begin
								state_q <= ST_PAIR;
							end
						end else begin
							base_q  <= hi_q;
							state_q <= ST_PAIR;
						end
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_FETCH: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Merge cursors: set per run pair, advance per written element
	always_ff @(posedge clk) begin
		if (state_q == ST_PAIR) begin
			mid_q <= pair_mid;
			hi_q  <= pair_hi;
			l_q   <= base_q;
			r_q   <= pair_mid;
			k_q   <= base_q;
		end else if (state_q == ST_WR) begin
			k_q <= k_inc;
			if (take_left) begin
				l_q <= l_q + 1'b1;
			end else begin
				r_q <= r_q + 1'b1;
			end
		end
	end

	// Output register: load on fetch completion, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FETCH) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FETCH) begin
			out_data_q          <= fetch_hit_q ? rd_a : '0;
			out_last_q          <= fetch_hit_q && fetch_last_q;
			out_user_q.empty    <= !fetch_hit_q;
			out_user_q.overflow <= ovf_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_user_q;

`ifndef SYNTHESIS
	// An empty result carries a zero value and no last mark
	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0 && !m_axis_tlast))
		else $error("empty result with nonzero value or last");

	// The fetch cursor never runs past the stored count
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_idx_q <= count_q)
		else $error("read index beyond item count");

	// Merge cursors stay inside their runs while merging
	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_WR) |-> (l_q <= mid_q && r_q <= hi_q && k_q < hi_q))
		else $error("merge cursor out of run bounds");

	// Completing the last pass marks the set sorted, returns to idle and rewinds the fetch cursor
	a_sorted_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR && k_inc == hi_q && hi_q == n_ext && w2 >= n_ext)
		|=> (sorted_q && state_q == ST_IDLE && rd_idx_q == '0))
		else $error("sort completion did not publish the set");
`endif

endmodule
